@@ hw/rtl/wesm_pkg.sv @@
// Shared constants and types for the wheel encoder speed meter.
// Used by the lane, the divider and the top level; depends on nothing.
package wesm_pkg;

    localparam int HistDepth    = 16;
    localparam int IntervalBits = 16;

    localparam int IDX_W   = $clog2(HistDepth);
    localparam int CNT_W   = $clog2(HistDepth + 1);
    localparam int SUM_W   = IntervalBits + $clog2(HistDepth);
    localparam int DEN_W   = SUM_W + 1;
    localparam int SCALE_W = 20;
    localparam int NUM_W   = SCALE_W + CNT_W;
    localparam int CMP_W   = (IntervalBits > 16) ? IntervalBits : 16;
    localparam int COUNT_W = 16;
    localparam int SPEED_W = 15;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [SPEED_W-1:0]      SPEED_MAX    = {SPEED_W{1'b1}};
    localparam logic [IntervalBits-1:0] ELAPSED_MAX  = {IntervalBits{1'b1}};

    localparam logic [4:0]         RST_AVG      = 5'd4;
    localparam logic [7:0]         RST_DEBOUNCE = 8'd10;
    localparam logic [15:0]        RST_STALE    = 16'd1000;
    localparam logic [SCALE_W-1:0] RST_SCALE    = SCALE_W'(47125);

    localparam logic [1:0] REG_AVG      = 2'd0;
    localparam logic [1:0] REG_DEBOUNCE = 2'd1;
    localparam logic [1:0] REG_STALE    = 2'd2;
    localparam logic [1:0] REG_SCALE    = 2'd3;

    typedef struct packed {
        logic upd;
        logic sum_start;
        logic div_start;
    } t_lane_ctl;

    typedef struct packed {
        logic sum_done;
        logic div_done;
    } t_lane_sts;

endpackage

@@ hw/rtl/wesm_div.sv @@
// Restoring divider, one quotient bit per cycle, quotient saturated to the speed range.
// Depends on wesm_pkg.
module wesm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [wesm_pkg::NUM_W-1:0]    i_num,
    input  logic [wesm_pkg::DEN_W-1:0]    i_den,
    output logic                          o_done,
    output logic [wesm_pkg::SPEED_W-1:0]  o_quot
);

    localparam int STEP_W = $clog2(wesm_pkg::NUM_W + 1);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(wesm_pkg::NUM_W - 1);

    logic                        r_busy;
    logic                        r_done;
    logic [STEP_W-1:0]           r_cnt;
    logic [wesm_pkg::DEN_W-1:0]  r_rem;
    logic [wesm_pkg::NUM_W-1:0]  r_quo;
    logic [wesm_pkg::DEN_W-1:0]  r_den;
    logic                        r_den_zero;

    logic [wesm_pkg::DEN_W:0]    trial;
    logic                        fits;
    logic [wesm_pkg::DEN_W-1:0]  n_rem;
    logic [wesm_pkg::NUM_W-1:0]  n_quo;

    always_comb begin
        trial = {r_rem, r_quo[wesm_pkg::NUM_W-1]};
        fits  = (trial >= {1'b0, r_den});
        n_rem = fits ? wesm_pkg::DEN_W'(trial - {1'b0, r_den})
                     : trial[wesm_pkg::DEN_W-1:0];
        n_quo = {r_quo[wesm_pkg::NUM_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem      <= '0;
            r_quo      <= i_num;
            r_den      <= i_den;
            r_den_zero <= (i_den == '0);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    always_comb begin
        if (r_den_zero) begin
            o_quot = '0;
        end else if (|r_quo[wesm_pkg::NUM_W-1:wesm_pkg::SPEED_W]) begin
            o_quot = wesm_pkg::SPEED_MAX;
        end else begin
            o_quot = r_quo[wesm_pkg::SPEED_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

@@ hw/rtl/wesm_lane.sv @@
// One wheel: elapsed timer, debounce, step counter, interval ring, windowed sum and speed.
// Depends on wesm_pkg and wesm_div.
module wesm_lane (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wesm_pkg::t_lane_ctl                 i_ctl,
    input  logic                                i_edge,
    input  logic signed [1:0]                   i_dir,
    input  logic                                i_clear,
    input  logic [7:0]                          i_debounce,
    input  logic [15:0]                         i_stale,
    input  logic [wesm_pkg::CNT_W-1:0]          i_navg,
    input  logic [wesm_pkg::NUM_W-1:0]          i_num,
    output wesm_pkg::t_lane_sts                 o_sts,
    output logic signed [wesm_pkg::COUNT_W-1:0] o_count,
    output logic [wesm_pkg::SUM_W-1:0]          o_sum,
    output logic signed [15:0]                  o_speed
);

    localparam int IB = wesm_pkg::IntervalBits;
    localparam int HD = wesm_pkg::HistDepth;
    localparam int IW = wesm_pkg::IDX_W;

    function automatic logic [IW-1:0] prev_idx(input logic [IW-1:0] idx);
        return (idx == '0) ? IW'(HD - 1) : IW'(idx - 1'b1);
    endfunction

    logic [IB-1:0]                 r_elapsed;
    logic [wesm_pkg::COUNT_W-1:0]  r_count;
    logic [IW-1:0]                 r_slot;
    logic [1:0]                    r_dir;
    logic [IB-1:0]                 r_ring [HD];
    logic [HD-1:0]                 r_vld;
    logic [IW-1:0]                 r_rd_idx;
    logic [wesm_pkg::CNT_W-1:0]    r_left;
    logic                          r_rd_vld;
    logic [IB-1:0]                 r_rd_data;
    logic                          r_rd_ok;
    logic [wesm_pkg::SUM_W-1:0]    r_sum;

    logic [IB-1:0]                 e_inc;
    logic                          edge_ok;
    logic [wesm_pkg::COUNT_W-1:0]  n_count;
    logic                          stale;
    logic [wesm_pkg::SPEED_W-1:0]  mag;
    logic                          div_done;

    always_comb begin
        e_inc   = (r_elapsed == wesm_pkg::ELAPSED_MAX) ? r_elapsed : IB'(r_elapsed + 1'b1);
        edge_ok = i_edge && (wesm_pkg::CMP_W'(e_inc) > wesm_pkg::CMP_W'(i_debounce));
        n_count = r_count;
        if (edge_ok) begin
            case (i_dir) inside
                2'b01:        n_count = r_count + 1'b1;
                2'b10, 2'b11: n_count = r_count - 1'b1;
                default:      n_count = r_count;
            endcase
        end
        if (i_clear) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_elapsed <= '0;
            r_count   <= '0;
            r_slot    <= '0;
            r_vld     <= '0;
            r_left    <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_ctl.upd) begin
                r_count <= n_count;
                if (edge_ok) begin
                    r_elapsed     <= '0;
                    r_vld[r_slot] <= 1'b1;
                    r_slot        <= (r_slot == IW'(HD - 1)) ? '0 : IW'(r_slot + 1'b1);
                end else begin
                    r_elapsed <= e_inc;
                end
            end
            if (i_ctl.sum_start) begin
                r_left   <= i_navg;
                r_rd_vld <= 1'b0;
            end else begin
                r_rd_vld <= (r_left != '0);
                if (r_left != '0) begin
                    r_left <= r_left - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.upd) begin
            r_dir <= i_dir;
            if (edge_ok) begin
                r_ring[r_slot] <= e_inc;
            end
        end
        if (i_ctl.sum_start) begin
            r_rd_idx <= prev_idx(r_slot);
            r_sum    <= '0;
        end else begin
            if (r_left != '0) begin
                r_rd_data <= r_ring[r_rd_idx];
                r_rd_ok   <= r_vld[r_rd_idx];
                r_rd_idx  <= prev_idx(r_rd_idx);
            end
            if (r_rd_vld && r_rd_ok) begin
                r_sum <= r_sum + wesm_pkg::SUM_W'(r_rd_data);
            end
        end
    end

    wesm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.div_start),
        .i_num   (i_num),
        .i_den   ({r_sum, 1'b0}),
        .o_done  (div_done),
        .o_quot  (mag)
    );

    always_comb begin
        stale = wesm_pkg::CMP_W'(r_elapsed) > wesm_pkg::CMP_W'(i_stale);
        if (stale || (r_dir == 2'b00)) begin
            o_speed = '0;
        end else if (r_dir[1]) begin
            o_speed = -$signed({1'b0, mag});
        end else begin
            o_speed = $signed({1'b0, mag});
        end
    end

    assign o_sts.sum_done = (r_left == '0) && !r_rd_vld;
    assign o_sts.div_done = div_done;
    assign o_count        = r_count;
    assign o_sum          = r_sum;

endmodule

@@ hw/rtl/wheel_encoder_speed_meter.sv @@
// Top level of the wheel encoder speed meter: register port, sequencer, two wheel lanes,
// merging divider for the combined speed and the output register.
// Depends on wesm_pkg, wesm_lane and wesm_div.
//
//  channel   signals                                     direction
//  input     i_in_valid, o_in_stall, i_edge_*, i_dir_*,   into the block, one tick per item
//            i_clear_*
//  output    o_out_valid, i_out_stall, o_count_*,         out of the block, one result per item
//            o_rotation_steps, o_speed_*, o_speed_mean
//  config    psel, penable, pwrite, paddr, pwdata,        APB-style register port
//            prdata, pready
//
// An item passes through the accept, the sum start, the serial sum over the interval ring
// (N entries, N being the average count clamped to the ring depth), the divider start, the
// bit-serial dividers and the output load, in that order; the sum runs until both lanes finish.
// The next item is taken once the result is in the output register; the result may wait
// there under stall while the next item is worked on, and a finished item waits in the
// output step for as long as the previous result is stalled.
// Reset is synchronous and clears the counters, ring valid bits and control state at once;
// the configuration returns to its reset values.
module wheel_encoder_speed_meter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_edge_left,
    input  logic                                i_edge_right,
    input  logic signed [1:0]                   i_dir_left,
    input  logic signed [1:0]                   i_dir_right,
    input  logic                                i_clear_left,
    input  logic                                i_clear_right,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [wesm_pkg::COUNT_W-1:0] o_count_left,
    output logic signed [wesm_pkg::COUNT_W-1:0] o_count_right,
    output logic signed [wesm_pkg::COUNT_W-1:0] o_rotation_steps,
    output logic signed [15:0]                  o_speed_left,
    output logic signed [15:0]                  o_speed_right,
    output logic [wesm_pkg::SPEED_W-1:0]        o_speed_mean,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wesm_pkg::ADDR_W-1:0]         paddr,
    input  logic [wesm_pkg::DATA_W-1:0]         pwdata,
    output logic [wesm_pkg::DATA_W-1:0]         prdata,
    output logic                                pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUMST,
        ST_SUM,
        ST_DIVST,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                            r_state;
    logic [4:0]                        r_avg;
    logic [7:0]                        r_debounce;
    logic [15:0]                       r_stale;
    logic [wesm_pkg::SCALE_W-1:0]      r_scale;
    logic [wesm_pkg::NUM_W-1:0]        r_num;
    logic                              r_out_valid;
    logic [wesm_pkg::COUNT_W-1:0]      r_count_left;
    logic [wesm_pkg::COUNT_W-1:0]      r_count_right;
    logic [wesm_pkg::COUNT_W-1:0]      r_rotation;
    logic [15:0]                       r_speed_left;
    logic [15:0]                       r_speed_right;
    logic [wesm_pkg::SPEED_W-1:0]      r_speed_mean;

    logic                              in_acc;
    logic                              out_free;
    logic                              load_out;
    logic                              cfg_wr;
    logic [1:0]                        reg_idx;
    logic [wesm_pkg::CNT_W-1:0]        navg;
    wesm_pkg::t_lane_ctl               ctl;
    wesm_pkg::t_lane_sts               sts_l;
    wesm_pkg::t_lane_sts               sts_r;
    logic signed [wesm_pkg::COUNT_W-1:0] cnt_l;
    logic signed [wesm_pkg::COUNT_W-1:0] cnt_r;
    logic [wesm_pkg::SUM_W-1:0]        sum_l;
    logic [wesm_pkg::SUM_W-1:0]        sum_r;
    logic signed [15:0]                spd_l;
    logic signed [15:0]                spd_r;
    logic                              mean_done;
    logic [wesm_pkg::SPEED_W-1:0]      mean_q;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg      <= wesm_pkg::RST_AVG;
            r_debounce <= wesm_pkg::RST_DEBOUNCE;
            r_stale    <= wesm_pkg::RST_STALE;
            r_scale    <= wesm_pkg::RST_SCALE;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                wesm_pkg::REG_AVG:      r_avg      <= pwdata[4:0];
                wesm_pkg::REG_DEBOUNCE: r_debounce <= pwdata[7:0];
                wesm_pkg::REG_STALE:    r_stale    <= pwdata[15:0];
                wesm_pkg::REG_SCALE:    r_scale    <= pwdata[wesm_pkg::SCALE_W-1:0];
                default:                r_avg      <= r_avg;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            wesm_pkg::REG_AVG:      prdata = wesm_pkg::DATA_W'(r_avg);
            wesm_pkg::REG_DEBOUNCE: prdata = wesm_pkg::DATA_W'(r_debounce);
            wesm_pkg::REG_STALE:    prdata = wesm_pkg::DATA_W'(r_stale);
            wesm_pkg::REG_SCALE:    prdata = wesm_pkg::DATA_W'(r_scale);
            default:                prdata = '0;
        endcase
    end

    assign navg = (int'(r_avg) > wesm_pkg::HistDepth) ? wesm_pkg::CNT_W'(wesm_pkg::HistDepth)
                                                       : wesm_pkg::CNT_W'(r_avg);

    assign o_in_stall    = (r_state != ST_IDLE);
    assign in_acc        = i_in_valid && !o_in_stall;
    assign out_free      = !r_out_valid || !i_out_stall;
    assign load_out      = (r_state == ST_OUT) && out_free;
    assign ctl.upd       = in_acc;
    assign ctl.sum_start = (r_state == ST_SUMST);
    assign ctl.div_start = (r_state == ST_DIVST);

    wesm_lane u_lane_left (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_edge     (i_edge_left),
        .i_dir      (i_dir_left),
        .i_clear    (i_clear_left),
        .i_debounce (r_debounce),
        .i_stale    (r_stale),
        .i_navg     (navg),
        .i_num      (r_num),
        .o_sts      (sts_l),
        .o_count    (cnt_l),
        .o_sum      (sum_l),
        .o_speed    (spd_l)
    );

    wesm_lane u_lane_right (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl),
        .i_edge     (i_edge_right),
        .i_dir      (i_dir_right),
        .i_clear    (i_clear_right),
        .i_debounce (r_debounce),
        .i_stale    (r_stale),
        .i_navg     (navg),
        .i_num      (r_num),
        .o_sts      (sts_r),
        .o_count    (cnt_r),
        .o_sum      (sum_r),
        .o_speed    (spd_r)
    );

    wesm_div u_div_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.div_start),
        .i_num   (r_num),
        .i_den   (wesm_pkg::DEN_W'(sum_l) + wesm_pkg::DEN_W'(sum_r)),
        .o_done  (mean_done),
        .o_quot  (mean_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_SUMST;
                    end
                end
                ST_SUMST: begin
                    r_num   <= wesm_pkg::NUM_W'(r_scale) * wesm_pkg::NUM_W'(navg);
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    if (sts_l.sum_done && sts_r.sum_done) begin
                        r_state <= ST_DIVST;
                    end
                end
                ST_DIVST: begin
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (mean_done) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_count_left  <= cnt_l;
                        r_count_right <= cnt_r;
                        r_rotation    <= cnt_r - cnt_l;
                        r_speed_left  <= spd_l;
                        r_speed_right <= spd_r;
                        r_speed_mean  <= mean_q;
                        r_state       <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_count_left     = r_count_left;
    assign o_count_right    = r_count_right;
    assign o_rotation_steps = r_rotation;
    assign o_speed_left     = r_speed_left;
    assign o_speed_right    = r_speed_right;
    assign o_speed_mean     = r_speed_mean;

    a_lanes_sum_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SUM) |-> (sts_l.sum_done == sts_r.sum_done))
        else $error("wheel lanes finished their sums in different cycles");

    a_dividers_in_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mean_done |-> (sts_l.div_done && sts_r.div_done))
        else $error("speed dividers finished in different cycles");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == ST_OUT) && out_free) |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("finished item was not placed in the output register");

endmodule

@@ dv/tb_wheel_encoder_speed_meter.sv @@
// Self-checking testbench for the wheel encoder speed meter: random and directed ticks are
// checked against a predictor of the counters, interval rings and speed divisions.
// Depends on wesm_pkg and the wheel_encoder_speed_meter RTL.
module tb_wheel_encoder_speed_meter;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int MAX_IDLE     = 17;
    localparam int DRAIN_CYCLES = 100;
    localparam int LONG_HOLD    = 400;

    localparam logic [1:0] DIR_STOP    = 2'b00;
    localparam logic [1:0] DIR_FWD     = 2'b01;
    localparam logic [1:0] DIR_REV_ALT = 2'b10;
    localparam logic [1:0] DIR_REV     = 2'b11;

    typedef struct packed {
        logic       edge_l;
        logic       edge_r;
        logic [1:0] dir_l;
        logic [1:0] dir_r;
        logic       clr_l;
        logic       clr_r;
    } t_tick;

    typedef struct packed {
        logic [15:0]                  count_l;
        logic [15:0]                  count_r;
        logic [15:0]                  rotation;
        logic [15:0]                  speed_l;
        logic [15:0]                  speed_r;
        logic [wesm_pkg::SPEED_W-1:0] speed_mean;
    } t_reading;

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic                                o_in_stall;
    logic                                i_edge_left = 1'b0;
    logic                                i_edge_right = 1'b0;
    logic signed [1:0]                   i_dir_left = 2'sb00;
    logic signed [1:0]                   i_dir_right = 2'sb00;
    logic                                i_clear_left = 1'b0;
    logic                                i_clear_right = 1'b0;
    logic                                o_out_valid;
    logic                                i_out_stall = 1'b0;
    logic signed [wesm_pkg::COUNT_W-1:0] o_count_left;
    logic signed [wesm_pkg::COUNT_W-1:0] o_count_right;
    logic signed [wesm_pkg::COUNT_W-1:0] o_rotation_steps;
    logic signed [15:0]                  o_speed_left;
    logic signed [15:0]                  o_speed_right;
    logic [wesm_pkg::SPEED_W-1:0]        o_speed_mean;
    logic                                psel = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite = 1'b0;
    logic [wesm_pkg::ADDR_W-1:0]         paddr = '0;
    logic [wesm_pkg::DATA_W-1:0]         pwdata = '0;
    logic [wesm_pkg::DATA_W-1:0]         prdata;
    logic                                pready;

    wheel_encoder_speed_meter i_dut (.*);

    always #2 i_clk = ~i_clk;

    // Predictor state: index 0 is the left wheel, index 1 the right wheel.
    logic [15:0]                       step_count [2];
    logic [wesm_pkg::IntervalBits-1:0] since_edge [2];
    logic [wesm_pkg::IntervalBits-1:0] interval_ring [2][wesm_pkg::HistDepth];
    logic [wesm_pkg::IDX_W-1:0]        ring_slot [2];
    logic [4:0]                        avg_cfg;
    logic [7:0]                        debounce_cfg;
    logic [15:0]                       stale_cfg;
    logic [wesm_pkg::SCALE_W-1:0]      scale_cfg;

    t_tick    pending_ticks [$];
    t_reading expected_readings [$];

    int  ticks_queued = 0;
    int  readings_checked = 0;
    int  mismatches = 0;
    int  cycles = 0;
    int  settings_used = 0;
    int  edges_taken = 0;
    int  stale_zeros = 0;
    int  capped_speeds = 0;
    bit  send_idle_on = 1'b1;
    bit  recv_idle_on = 1'b1;
    int  hold_requests = 0;
    int  hold_served = 0;
    int  hold_left = 0;
    logic recv_hold = 1'b0;

    t_tick    on_offer;
    bit       offering = 1'b0;
    int       send_gap = 0;
    int       recv_gap = 0;
    t_reading want;

    function automatic void reset_model();
        for (int s = 0; s < 2; s++) begin
            step_count[s] = '0;
            since_edge[s] = '0;
            ring_slot[s]  = '0;
            for (int k = 0; k < wesm_pkg::HistDepth; k++) begin
                interval_ring[s][k] = '0;
            end
        end
        avg_cfg      = wesm_pkg::RST_AVG;
        debounce_cfg = wesm_pkg::RST_DEBOUNCE;
        stale_cfg    = wesm_pkg::RST_STALE;
        scale_cfg    = wesm_pkg::RST_SCALE;
    endfunction

    function automatic int dir_sign(logic [1:0] code);
        if (code == DIR_STOP) return 0;
        return code[1] ? -1 : 1;
    endfunction

    function automatic longint unsigned avg_taken();
        return (avg_cfg > wesm_pkg::HistDepth) ? wesm_pkg::HistDepth : avg_cfg;
    endfunction

    function automatic longint unsigned interval_sum(int side);
        longint unsigned acc;
        logic [wesm_pkg::IDX_W-1:0] idx;
        acc = 0;
        idx = ring_slot[side];
        for (int k = 0; k < avg_taken(); k++) begin
            idx = idx - 1'b1;
            acc = acc + interval_ring[side][idx];
        end
        return acc;
    endfunction

    function automatic longint unsigned capped_quotient(longint unsigned num,
                                                        longint unsigned den);
        longint unsigned q;
        if (den == 0) return 0;
        q = num / den;
        if (q > wesm_pkg::SPEED_MAX) begin
            capped_speeds++;
            return wesm_pkg::SPEED_MAX;
        end
        return q;
    endfunction

    function automatic void advance_wheel(int side, logic edge_seen, logic [1:0] code,
                                          logic clr);
        int s;
        s = dir_sign(code);
        if (since_edge[side] != wesm_pkg::ELAPSED_MAX)
            since_edge[side] = since_edge[side] + 1'b1;
        if (edge_seen && since_edge[side] > debounce_cfg) begin
            if (s > 0) step_count[side] = step_count[side] + 1'b1;
            else if (s < 0) step_count[side] = step_count[side] - 1'b1;
            interval_ring[side][ring_slot[side]] = since_edge[side];
            ring_slot[side] = ring_slot[side] + 1'b1;
            since_edge[side] = '0;
            edges_taken++;
        end
        if (clr) step_count[side] = '0;
    endfunction

    function automatic logic [15:0] wheel_speed(int side, logic [1:0] code);
        longint unsigned mag;
        longint unsigned sc;
        int s;
        s = dir_sign(code);
        if (s == 0) return '0;
        if (since_edge[side] > stale_cfg) begin
            stale_zeros++;
            return '0;
        end
        sc = scale_cfg;
        mag = capped_quotient(sc * avg_taken(), 2 * interval_sum(side));
        return (s < 0) ? 16'(-mag) : 16'(mag);
    endfunction

    function automatic t_reading predict_reading(t_tick t);
        t_reading r;
        longint unsigned sc;
        advance_wheel(0, t.edge_l, t.dir_l, t.clr_l);
        advance_wheel(1, t.edge_r, t.dir_r, t.clr_r);
        sc = scale_cfg;
        r.count_l    = step_count[0];
        r.count_r    = step_count[1];
        r.rotation   = step_count[1] - step_count[0];
        r.speed_l    = wheel_speed(0, t.dir_l);
        r.speed_r    = wheel_speed(1, t.dir_r);
        r.speed_mean = wesm_pkg::SPEED_W'(capped_quotient(sc * avg_taken(),
                                          interval_sum(0) + interval_sum(1)));
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] exp_val);
        $display("[%0t] mismatch on %s: got 0x%04h, expected 0x%04h after %0d readings",
                 $realtime, what, got, exp_val, readings_checked);
        mismatches++;
    endtask

    task automatic push_tick(input logic el, input logic er, input logic [1:0] dl,
                             input logic [1:0] dr, input logic cl, input logic cr);
        t_tick t;
        t.edge_l = el;
        t.edge_r = er;
        t.dir_l  = dl;
        t.dir_r  = dr;
        t.clr_l  = cl;
        t.clr_r  = cr;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic wait_drained();
        while (readings_checked != ticks_queued) @(posedge i_clk);
    endtask

    task automatic reg_write(input logic [1:0] which,
                             input logic [wesm_pkg::DATA_W-1:0] value);
        int width;
        logic [wesm_pkg::DATA_W-1:0] mask;
        logic [wesm_pkg::DATA_W-1:0] bus;
        case (which)
            wesm_pkg::REG_AVG:      width = 5;
            wesm_pkg::REG_DEBOUNCE: width = 8;
            wesm_pkg::REG_STALE:    width = 16;
            default:                width = wesm_pkg::SCALE_W;
        endcase
        mask = (wesm_pkg::DATA_W'(1) << width) - 1'b1;
        bus = value & mask;
        if ($urandom_range(0, 3) == 0) bus = bus | ($urandom & ~mask);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {which, 2'b00};
        pwdata  <= bus;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (which)
            wesm_pkg::REG_AVG:      avg_cfg = bus[4:0];
            wesm_pkg::REG_DEBOUNCE: debounce_cfg = bus[7:0];
            wesm_pkg::REG_STALE:    stale_cfg = bus[15:0];
            default:                scale_cfg = bus[wesm_pkg::SCALE_W-1:0];
        endcase
    endtask

    task automatic set_config(input int avg, input int deb, input int stale, input int scale);
        wait_drained();
        repeat (4) @(posedge i_clk);
        reg_write(wesm_pkg::REG_AVG, avg);
        reg_write(wesm_pkg::REG_DEBOUNCE, deb);
        reg_write(wesm_pkg::REG_STALE, stale);
        reg_write(wesm_pkg::REG_SCALE, scale);
        settings_used++;
    endtask

    // Each wheel fires edges at a random period just above the debounce time, with
    // occasional bounce edges, direction changes and counter clears mixed in.
    task automatic queue_random_ticks(input int n);
        int due [2];
        logic fire [2];
        logic [1:0] heading [2];
        for (int s = 0; s < 2; s++) begin
            due[s] = $urandom_range(1, debounce_cfg + 40);
            heading[s] = 2'($urandom_range(0, 3));
        end
        repeat (n) begin
            for (int s = 0; s < 2; s++) begin
                if (due[s] <= 1) begin
                    fire[s] = 1'b1;
                    due[s] = debounce_cfg + $urandom_range(1, 40);
                end else begin
                    due[s]--;
                    fire[s] = ($urandom_range(0, 15) == 0);
                end
                if ($urandom_range(0, 49) == 0) heading[s] = 2'($urandom_range(0, 3));
            end
            push_tick(fire[0], fire[1], heading[0], heading[1],
                      $urandom_range(0, 39) == 0, $urandom_range(0, 39) == 0);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            offering = 1'b0;
            send_gap = 0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                expected_readings.push_back(predict_reading(on_offer));
                offering = 1'b0;
            end
            if (!offering) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_ticks.size() > 0) begin
                    on_offer = pending_ticks.pop_front();
                    i_edge_left   <= on_offer.edge_l;
                    i_edge_right  <= on_offer.edge_r;
                    i_dir_left    <= on_offer.dir_l;
                    i_dir_right   <= on_offer.dir_r;
                    i_clear_left  <= on_offer.clr_l;
                    i_clear_right <= on_offer.clr_r;
                    offering = 1'b1;
                    send_gap = send_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
                end
            end
            i_in_valid <= offering;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            recv_gap = 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_readings.size() == 0) begin
                    report_mismatch("result with no pending tick", 16'h0, 16'h0);
                end else begin
                    want = expected_readings.pop_front();
                    if (o_count_left !== want.count_l)
                        report_mismatch("count_left", o_count_left, want.count_l);
                    if (o_count_right !== want.count_r)
                        report_mismatch("count_right", o_count_right, want.count_r);
                    if (o_rotation_steps !== want.rotation)
                        report_mismatch("rotation_steps", o_rotation_steps, want.rotation);
                    if (o_speed_left !== want.speed_l)
                        report_mismatch("speed_left", o_speed_left, want.speed_l);
                    if (o_speed_right !== want.speed_r)
                        report_mismatch("speed_right", o_speed_right, want.speed_r);
                    if (o_speed_mean !== want.speed_mean)
                        report_mismatch("speed_mean", 16'(o_speed_mean), 16'(want.speed_mean));
                    readings_checked++;
                end
                recv_gap = recv_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end else if (recv_gap > 0) begin
                recv_gap--;
            end
            i_out_stall <= recv_hold || (recv_gap > 0);
        end
    end

    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
        end else if (hold_served != hold_requests) begin
            hold_left = LONG_HOLD;
            hold_served++;
        end
        recv_hold <= (hold_left > 0);
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL wheel_encoder_speed_meter");
        $finish;
    end

    initial begin
        reset_model();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: a bounced edge, an accepted one with the alternate reverse code,
        // then a clear together with an edge.
        push_tick(1'b0, 1'b0, DIR_STOP, DIR_STOP, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, DIR_FWD, DIR_REV, 1'b0, 1'b0);
        repeat (9) push_tick(1'b0, 1'b0, DIR_FWD, DIR_REV, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, DIR_FWD, DIR_REV_ALT, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, DIR_REV, DIR_FWD, 1'b1, 1'b1);

        // No debounce, shortest non-zero stale time, largest scale and an average count
        // above the ring depth.
        set_config(31, 0, 1, (1 << wesm_pkg::SCALE_W) - 1);
        push_tick(1'b1, 1'b1, DIR_FWD, DIR_REV, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, DIR_FWD, DIR_FWD, 1'b1, 1'b0);
        push_tick(1'b1, 1'b1, DIR_STOP, DIR_REV_ALT, 1'b0, 1'b1);
        push_tick(1'b0, 1'b0, DIR_FWD, DIR_REV, 1'b0, 1'b0);
        push_tick(1'b0, 1'b0, DIR_FWD, DIR_REV, 1'b0, 1'b0);
        push_tick(1'b1, 1'b1, DIR_REV_ALT, DIR_REV_ALT, 1'b1, 1'b1);
        push_tick(1'b1, 1'b1, DIR_REV, DIR_REV, 1'b0, 1'b0);

        // A zero average count makes every speed zero.
        set_config(0, 0, 1000, 47125);
        push_tick(1'b1, 1'b1, DIR_FWD, DIR_FWD, 1'b0, 1'b0);
        push_tick(1'b0, 1'b1, DIR_REV, DIR_FWD, 1'b0, 1'b0);

        set_config(1, 255, 65535, 1);
        queue_random_ticks(120);

        set_config(16, 0, 1, (1 << wesm_pkg::SCALE_W) - 1);
        send_idle_on = 1'b0;
        recv_idle_on = 1'b0;
        queue_random_ticks(250);

        for (int phase = 0; phase < 6; phase++) begin
            set_config(($urandom_range(0, 9) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(1, 16),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(0, 255)
                                                   : $urandom_range(0, 20),
                       ($urandom_range(0, 2) == 0) ? $urandom_range(1, 40)
                       : ($urandom_range(0, 1) == 0) ? $urandom_range(40, 400)
                                                     : $urandom_range(1, 65535),
                       $urandom_range(1, (1 << wesm_pkg::SCALE_W) - 1));
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            queue_random_ticks(120);
            if (phase == 0) hold_requests++;
            wait_drained();
            queue_random_ticks(120);
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_readings.size() != 0)
            report_mismatch("readings never delivered", 16'(expected_readings.size()), 16'h0);
        $display("Checked %0d tick readings under %0d register settings in %0d cycles.",
                 readings_checked, settings_used, cycles);
        $display("Saw %0d accepted wheel edges, %0d stale speed zeros, %0d capped quotients.",
                 edges_taken, stale_zeros, capped_speeds);
        if (mismatches == 0) begin
            $display("PASS wheel_encoder_speed_meter");
        end else begin
            $display("FAIL wheel_encoder_speed_meter");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/wesm_pkg.sv
hw/rtl/wesm_div.sv
hw/rtl/wesm_lane.sv
hw/rtl/wheel_encoder_speed_meter.sv
dv/tb_wheel_encoder_speed_meter.sv
